// File: rtl/murmur3_32_byte_hasher_core_assert.svh
// ============================================================================
// Assertion macros for the MurmurHash3 byte hasher
// Concurrent assertion wrappers that fall away when SYNTH is defined.
// ============================================================================
`ifndef MURMUR3_32_BYTE_HASHER_CORE_ASSERT_SVH
`define MURMUR3_32_BYTE_HASHER_CORE_ASSERT_SVH

`ifndef SYNTH

// Property checked on every clock edge outside reset.
`define MM3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MM3_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MM3_ASSERT(label, clk, rst_n, prop, msg)
`define MM3_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/mm3_pkg.sv
// ============================================================================
// MurmurHash3 byte hasher package
// Shared constants, the queued item type and the rotate helpers.
// ============================================================================
`default_nettype none

package mm3_pkg;

    // Default width of the key length counter.
    localparam int LENGTH_BITS_DEF = 32;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;

    // Mixing and finaliser constants of the x86_32 variant.
    localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2   = 32'h1b873593;
    localparam logic [31:0] FOLD_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;

    // One classified beat as it waits in the queue.
    typedef struct packed {
        logic       has_byte;
        logic       last;
        logic [7:0] data;
    } t_item;

    // Left rotations used by the block mix and the hash fold.
    function automatic logic [31:0] rotl15(input logic [31:0] v);
        rotl15 = {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        rotl13 = {v[18:0], v[31:19]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/mm3_front.sv
// ============================================================================
// MurmurHash3 front part
// Accepts input beats, drops idle beats and queues the rest for the back.
// ============================================================================
`default_nettype none

module mm3_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_data,
    input  wire logic           i_last,
    input  wire logic           i_none,
    output mm3_pkg::t_item      o_item,
    output logic                o_item_valid,
    input  wire logic           i_pop
);
    import mm3_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_item            r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    t_item            w_item;

    // Classify the beat: an idle beat (no byte, not last) is taken and dropped.
    assign o_ready  = (r_count != CNT_FULL);
    assign w_accept = i_valid && o_ready;
    assign w_push   = w_accept && (!i_none || i_last);
    assign w_pop    = i_pop && (r_count != '0);

    always_comb begin
        w_item.has_byte = !i_none;
        w_item.last     = i_last;
        w_item.data     = i_data;
    end

    // Queue pointers and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    assign o_item       = r_q[r_rd_ptr];
    assign o_item_valid = (r_count != '0);

endmodule

`default_nettype wire

// File: rtl/mm3_back.sv
// ============================================================================
// MurmurHash3 back part
// Packs bytes into blocks, mixes and folds them, and finalises each key
// with one shared multiplier driven by a small sequencer.
// ============================================================================
`default_nettype none
`include "murmur3_32_byte_hasher_core_assert.svh"

module mm3_back #(
    parameter int LENGTH_BITS = mm3_pkg::LENGTH_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [31:0]    i_seed,
    input  wire mm3_pkg::t_item i_item,
    input  wire logic           i_item_valid,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [31:0]         o_hash
);
    import mm3_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL1 = 8'b0000_0010,
        ST_MUL2 = 8'b0000_0100,
        ST_FOLD = 8'b0000_1000,
        ST_TAIL = 8'b0001_0000,
        ST_FIN1 = 8'b0010_0000,
        ST_FIN2 = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

    t_state                 r_state, n_state;
    logic [31:0]            r_hash, n_hash;
    logic [31:0]            r_acc, n_acc;
    logic [31:0]            r_buf, n_buf;
    logic [1:0]             r_cnt, n_cnt;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_open, n_open;
    logic                   r_fin, n_fin;
    logic                   r_tail, n_tail;
    logic                   r_out_valid, n_out_valid;
    logic [31:0]            r_out, n_out;

    logic [31:0]            w_mul_a;
    logic [31:0]            w_mul_b;
    logic [31:0]            w_prod;
    logic [31:0]            w_buf_new;
    logic [31:0]            w_fin1;
    logic [31:0]            w_fin2;
    logic [31:0]            w_base;
    logic                   w_load_out;

    // Byte merged into the partial block at its little-endian position.
    assign w_buf_new = r_buf | (32'(i_item.data) << {r_cnt, 3'b000});

    // Finaliser steps that precede each multiplication.
    assign w_fin1 = (r_acc ^ 32'(r_len)) ^ ((r_acc ^ 32'(r_len)) >> 16);
    assign w_fin2 = r_acc ^ (r_acc >> 13);
    assign w_base = r_open ? r_hash : i_seed;

    // Shared multiplier: operands chosen by the sequencer step.
    always_comb begin
        w_mul_a = r_acc;
        w_mul_b = MIX_C1;
        unique case (r_state)
            ST_MUL2: begin
                w_mul_a = rotl15(r_acc);
                w_mul_b = MIX_C2;
            end
            ST_FIN1: begin
                w_mul_a = w_fin1;
                w_mul_b = FIN_M1;
            end
            ST_FIN2: begin
                w_mul_a = w_fin2;
                w_mul_b = FIN_M2;
            end
            default: begin
                w_mul_a = r_acc;
                w_mul_b = MIX_C1;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign o_pop      = (r_state == ST_IDLE) && i_item_valid;
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_acc       = r_acc;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_open      = r_open;
        n_fin       = r_fin;
        n_tail      = r_tail;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    if (i_item.has_byte) begin
                        if (!r_open) begin
                            n_hash = i_seed;
                            n_open = 1'b1;
                        end
                        n_len = r_len + LENGTH_BITS'(1);
                        if (r_cnt == 2'd3) begin
                            n_acc   = w_buf_new;
                            n_buf   = '0;
                            n_cnt   = '0;
                            n_fin   = i_item.last;
                            n_tail  = 1'b0;
                            n_state = ST_MUL1;
                        end else begin
                            n_buf   = w_buf_new;
                            n_cnt   = r_cnt + 2'd1;
                            n_state = i_item.last ? ST_TAIL : ST_IDLE;
                        end
                    end else begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_MUL1: begin
                n_acc   = w_prod;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_acc   = w_prod;
                n_state = ST_FOLD;
            end
            ST_FOLD: begin
                if (r_tail) begin
                    n_acc   = r_hash ^ r_acc;
                    n_state = ST_FIN1;
                end else begin
                    // Times five as a shift and add.
                    n_hash  = (rotl13(r_hash ^ r_acc) << 2) + rotl13(r_hash ^ r_acc)
                              + FOLD_ADD;
                    n_state = r_fin ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                // Mix any leftover tail bytes, otherwise go straight to the finaliser.
                if (r_cnt != 2'd0) begin
                    n_acc   = r_buf;
                    n_tail  = 1'b1;
                    n_state = ST_MUL1;
                end else begin
                    n_acc   = w_base;
                    n_state = ST_FIN1;
                end
            end
            ST_FIN1: begin
                n_acc   = w_prod;
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                n_acc   = w_prod;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_out       = r_acc ^ (r_acc >> 16);
                    n_out_valid = 1'b1;
                    n_open      = 1'b0;
                    n_buf       = '0;
                    n_cnt       = '0;
                    n_len       = '0;
                    n_fin       = 1'b0;
                    n_tail      = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_buf       <= '0;
            r_cnt       <= '0;
            r_len       <= '0;
            r_open      <= 1'b0;
            r_fin       <= 1'b0;
            r_tail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
            r_len       <= n_len;
            r_open      <= n_open;
            r_fin       <= n_fin;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_hash  = r_out;

    // A partial block only exists inside an open key.
    `MM3_ASSERT(a_cnt_needs_open, i_clk, i_rst_n,
        (r_cnt != 2'd0) |-> r_open, "partial block without open key")
    // The tail and finish flags never survive back to idle.
    `MM3_ASSERT(a_idle_no_tail, i_clk, i_rst_n,
        (r_state == ST_IDLE) |-> (!r_tail && !r_fin), "stale tail or finish flag in idle")
    // Emitting a hash clears the key state on the next edge.
    `MM3_ASSERT(a_emit_clears, i_clk, i_rst_n,
        w_load_out |=> (!r_open && (r_len == '0) && r_out_valid),
        "key state not cleared after emit")
    // The queue is only drained while the sequencer is idle.
    `MM3_ASSERT(a_pop_in_idle, i_clk, i_rst_n,
        o_pop |=> (($past(r_state) == ST_IDLE) && ($past(i_item_valid))), "pop outside idle")

endmodule

`default_nettype wire

// File: rtl/murmur3_32_byte_hasher_core.sv
// ============================================================================
// MurmurHash3 x86_32 byte hasher
// Streams a key one byte per beat and emits its 32-bit hash after the last beat.
// ============================================================================
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   key byte, tlast, tuser = no byte
//  m_axis    out        m_axis_tvalid/m_axis_tready   32-bit hash
//  cfg       in         i_cfg_valid/o_cfg_ready       hash seed
//
//  Every fourth byte runs the block mix and fold (ST_MUL1, ST_MUL2, ST_FOLD),
//  which share one 32x32 multiplier with the finaliser.
//  The last beat adds the tail mix and finaliser (ST_TAIL, ST_FIN1, ST_FIN2).
//  A two-beat queue decouples input acceptance from the sequencer, and the
//  output register lets the next key start while a hash waits to be taken.
//  Synchronous active-low reset clears the key control state and the seed to zero.
//
`default_nettype none

module murmur3_32_byte_hasher_core #(
    parameter int LENGTH_BITS = mm3_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic        s_axis_tlast,  // last_byte
    input  wire logic        s_axis_tuser,  // [0] no_byte
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] hash_value
    // Seed register write.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);
    import mm3_pkg::*;

    logic [31:0] r_seed;
    t_item       w_item;
    logic        w_item_valid;
    logic        w_pop;

    // Seed register, written whenever a beat arrives on the config channel.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    mm3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_none       (s_axis_tuser),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_pop        (w_pop)
    );

    mm3_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_hash       (m_axis_tdata)
    );

endmodule

`default_nettype wire
